>>> rtl/pct_pkg.sv
// ----------------------------------------------------------------------------
// pct_pkg
// Shared types, codes and helper functions of the percent codec.
// ----------------------------------------------------------------------------
package pct_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_MODE     = 2'd0;
	localparam logic [1:0] CFG_ESC_LOW  = 2'd1;
	localparam logic [1:0] CFG_ESC_HIGH = 2'd2;

	// Register widths and reset values
	localparam int unsigned CFG_DATA_W = 64;
	localparam logic [63:0] ESC_LOW_RST  = 64'hAC00_9FFF_0000_0000;
	localparam logic [63:0] ESC_HIGH_RST = 64'h0000_0000_2800_0001;

	// Mode values
	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	// Characters and digit offsets
	localparam logic [7:0] CHAR_PCT   = 8'h25;
	localparam logic [7:0] DIG_OFS    = 8'd48;
	localparam logic [7:0] UPPER_OFS  = 8'd55;
	localparam logic [7:0] LOWER_OFS  = 8'd87;
	localparam logic [4:0] HEX_NONE   = 5'h10;

	// Most results one input item can cause
	localparam int unsigned MAX_RES = 3;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HIGH = 2'd1,
		PH_LOW  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_HEX  = 2'd1,
		ERR_CUT  = 2'd2
	} err_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_marker;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_status;
		logic [1:0] error_code;
		logic       last_in_run;
	} out_item_t;

	// Group of results caused by one input item
	typedef struct packed {
		logic [1:0]               cnt;
		logic [MAX_RES-1:0][7:0] bytes;
		logic                     is_status;
		logic [1:0]               error_code;
	} group_t;

	// Uppercase ASCII hex digit of a nibble
	function automatic logic [7:0] hex_up(input logic [3:0] nib);
		logic [7:0] ext;
		begin
			ext = {4'b0000, nib};
			hex_up = ext + ((nib <= 4'd9) ? DIG_OFS : UPPER_OFS);
		end
	endfunction

	// Value of a hex digit in either case, or HEX_NONE if not a digit
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'd0;
			hex_val = HEX_NONE;
			if (c >= 8'h41 && c <= 8'h46) begin
				d = c - UPPER_OFS;
				hex_val = d[4:0];
			end else if (c >= 8'h61 && c <= 8'h66) begin
				d = c - LOWER_OFS;
				hex_val = d[4:0];
			end else if (c >= 8'h30 && c <= 8'h39) begin
				d = c - DIG_OFS;
				hex_val = d[4:0];
			end
		end
	endfunction

endpackage

>>> rtl/percent_codec_top.sv
// ----------------------------------------------------------------------------
// percent_codec_top
// Percent codec on a byte stream: encodes bytes into %XX escapes or decodes
// escapes back into bytes, with an end-marker status result.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle. Its results are computed in the same
// cycle and stored as a group in a two-entry group queue, which the output
// side drains one result per cycle while the sink does not stall. A
// pass-through byte, decoded byte or status is one result; an encoded escape
// is three, so a stream made only of escaped bytes is limited by the single
// output port. Bytes that cause no result (escape start, first hex digit,
// dropped bytes after an error) never occupy the queue. Input stalls only
// while both queue entries are full.
module percent_codec_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [pct_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            src_valid,
	output logic                            src_stall,
	input  pct_pkg::in_item_t               src_item,
	output logic                            dst_valid,
	input  logic                            dst_stall,
	output pct_pkg::out_item_t              dst_item
);

	logic               take;
	logic               push;
	logic               pop;
	pct_pkg::group_t    grp;
	pct_pkg::group_t    grp_q [2];
	pct_pkg::group_t    head;
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic [1:0]         idx_q;
	logic               last_res;

	assign src_stall = (count_q == 2'd2);
	assign take      = src_valid & ~src_stall;

	pct_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.item      (src_item),
		.grp       (grp)
	);

	assign push     = take & (grp.cnt != 2'd0);
	assign head     = grp_q[rd_ptr_q];
	assign last_res = (idx_q == (head.cnt - 2'd1));
	assign pop      = dst_valid & ~dst_stall & last_res;

	// Store result groups
	always_ff @(posedge clk) begin
		if (push) begin
			grp_q[wr_ptr_q] <= grp;
		end
	end

	// Advance queue pointers and the result index within the head group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
			idx_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
				idx_q    <= 2'd0;
			end else if (dst_valid & ~dst_stall) begin
				idx_q <= idx_q + 2'd1;
			end
			if (push & ~pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop & ~push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Drive the current result of the head group
	assign dst_valid            = (count_q != 2'd0);
	assign dst_item.out_byte    = head.bytes[idx_q];
	assign dst_item.is_status   = head.is_status;
	assign dst_item.error_code  = head.error_code;
	assign dst_item.last_in_run = last_res;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("group queue count out of range");

	a_head_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid |-> (head.cnt != 2'd0) && (idx_q < head.cnt))
		else $error("result index outside head group");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_item.is_status |-> dst_item.last_in_run)
		else $error("status result not last of its group");

	a_data_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_item.is_status |-> dst_item.error_code == pct_pkg::ERR_NONE)
		else $error("data result carries an error code");
`endif

endmodule

>>> rtl/pct_step.sv
// ----------------------------------------------------------------------------
// pct_step
// Configuration registers, decoder state, and per-byte encode/decode logic
// that turns one input item into a group of up to three results.
// ----------------------------------------------------------------------------
module pct_step (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [pct_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            take,
	input  pct_pkg::in_item_t               item,
	output pct_pkg::group_t                 grp
);

	logic                mode_q;
	logic [63:0]         esc_low_q;
	logic [63:0]         esc_high_q;
	pct_pkg::phase_t     phase_q, phase_d;
	logic [3:0]          high_nib_q, high_nib_d;
	pct_pkg::err_t       err_seen_q, err_seen_d;

	logic [127:0]        esc_map;
	logic                must_esc;
	logic [4:0]          hv;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= pct_pkg::MODE_ENCODE;
			esc_low_q  <= pct_pkg::ESC_LOW_RST;
			esc_high_q <= pct_pkg::ESC_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pct_pkg::CFG_MODE:     mode_q     <= cfg_data[0];
				pct_pkg::CFG_ESC_LOW:  esc_low_q  <= cfg_data;
				pct_pkg::CFG_ESC_HIGH: esc_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign esc_map  = {esc_high_q, esc_low_q};
	assign must_esc = item.in_byte[7] | esc_map[item.in_byte[6:0]];
	assign hv       = pct_pkg::hex_val(item.in_byte);

	// Build the result group and the next decoder state
	always_comb begin
		grp            = '0;
		phase_d        = phase_q;
		high_nib_d     = high_nib_q;
		err_seen_d     = err_seen_q;
		if (item.end_marker) begin
			grp.cnt       = 2'd1;
			grp.is_status = 1'b1;
			if (mode_q == pct_pkg::MODE_DECODE) begin
				if (err_seen_q != pct_pkg::ERR_NONE) begin
					grp.error_code = err_seen_q;
				end else if (phase_q != pct_pkg::PH_IDLE) begin
					grp.error_code = pct_pkg::ERR_CUT;
				end
			end
			phase_d    = pct_pkg::PH_IDLE;
			high_nib_d = 4'd0;
			err_seen_d = pct_pkg::ERR_NONE;
		end else if (mode_q == pct_pkg::MODE_ENCODE) begin
			if (must_esc) begin
				grp.cnt      = 2'd3;
				grp.bytes[0] = pct_pkg::CHAR_PCT;
				grp.bytes[1] = pct_pkg::hex_up(item.in_byte[7:4]);
				grp.bytes[2] = pct_pkg::hex_up(item.in_byte[3:0]);
			end else begin
				grp.cnt      = 2'd1;
				grp.bytes[0] = item.in_byte;
			end
		end else if (err_seen_q == pct_pkg::ERR_NONE) begin
			if (phase_q == pct_pkg::PH_IDLE) begin
				if (item.in_byte == pct_pkg::CHAR_PCT) begin
					phase_d = pct_pkg::PH_HIGH;
				end else begin
					grp.cnt      = 2'd1;
					grp.bytes[0] = item.in_byte;
				end
			end else if (hv[4]) begin
				err_seen_d = pct_pkg::ERR_HEX;
				phase_d    = pct_pkg::PH_IDLE;
			end else if (phase_q == pct_pkg::PH_HIGH) begin
				high_nib_d = hv[3:0];
				phase_d    = pct_pkg::PH_LOW;
			end else begin
				grp.cnt      = 2'd1;
				grp.bytes[0] = {high_nib_q, hv[3:0]};
				phase_d      = pct_pkg::PH_IDLE;
				high_nib_d   = 4'd0;
			end
		end
	end

	// Advance decoder state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= pct_pkg::PH_IDLE;
			high_nib_q <= 4'd0;
			err_seen_q <= pct_pkg::ERR_NONE;
		end else if (take) begin
			phase_q    <= phase_d;
			high_nib_q <= high_nib_d;
			err_seen_q <= err_seen_d;
		end
	end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for percent_codec_top. A queue-fed driver offers input
// bytes and end markers, a monitor compares every output transfer with the
// results of an in-bench model of the codec, and an initial block sequences
// directed strings, register settings, random strings and back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
	import pct_pkg::*;

	localparam int HOLD_CYCLES    = 90;
	localparam int TAIL_CYCLES    = 8;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int REPORT_LIMIT   = 10;
	localparam int RAND_PHASES    = 12;
	localparam int PHASE_ITEMS    = 30;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UPPER = 8'h41;
	localparam logic [7:0] CH_LOWER = 8'h61;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        src_valid = 1'b0;
	logic        src_stall;
	in_item_t    src_item = '0;
	logic        dst_valid;
	logic        dst_stall = 1'b0;
	out_item_t   dst_item;

	// Codec model: registers and string state
	logic        mode_m;
	logic [63:0] esc_low_m;
	logic [63:0] esc_high_m;
	phase_t      phase_m;
	logic [3:0]  hi_nib_m;
	err_t        err_m;

	in_item_t  src_feed_q[$];
	out_item_t codec_out_q[$];
	out_item_t oldest_out;

	int src_idle_pct;
	int dst_idle_pct;
	int hold_req_n;
	int hold_served;
	int hold_left;
	int idle_cycles;
	int src_taken;
	int results_seen;
	int bad_count;
	int status_ok;
	int status_hex;
	int status_cut;
	int phases_run;

	percent_codec_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_item  (dst_item)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Uppercase hex character of a nibble
	function automatic logic [7:0] nib_char(input logic [3:0] nib);
		if (nib < 4'd10)
			return CH_ZERO + {4'd0, nib};
		return CH_UPPER + {4'd0, nib} - 8'd10;
	endfunction

	// Nibble value of a hex character, bit 4 set when it is not one
	function automatic logic [4:0] char_nib(input logic [7:0] c);
		if (c >= CH_ZERO && c < CH_ZERO + 8'd10)
			return {1'b0, 4'(c - CH_ZERO)};
		if (c >= CH_UPPER && c < CH_UPPER + 8'd6)
			return {1'b0, 4'(c - CH_UPPER + 8'd10)};
		if (c >= CH_LOWER && c < CH_LOWER + 8'd6)
			return {1'b0, 4'(c - CH_LOWER + 8'd10)};
		return HEX_NONE;
	endfunction

	function automatic out_item_t make_out(input logic [7:0] b, input logic st,
			input err_t code);
		out_item_t r;
		r = '0;
		r.out_byte   = b;
		r.is_status  = st;
		r.error_code = code;
		return r;
	endfunction

	// Advance the codec model by one input transfer and queue its results
	function automatic void percent_step(input in_item_t it);
		out_item_t  res[MAX_RES];
		int         n;
		logic [7:0] b;
		logic [4:0] v;
		err_t       code;
		n = 0;
		b = it.in_byte;
		if (it.end_marker) begin
			code = ERR_NONE;
			if (mode_m == MODE_DECODE) begin
				if (err_m != ERR_NONE)
					code = err_m;
				else if (phase_m != PH_IDLE)
					code = ERR_CUT;
			end
			res[0] = make_out(8'd0, 1'b1, code);
			n = 1;
			phase_m  = PH_IDLE;
			hi_nib_m = 4'd0;
			err_m    = ERR_NONE;
		end else if (mode_m == MODE_ENCODE) begin
			if (b[7] || (b[6] ? esc_high_m[b[5:0]] : esc_low_m[b[5:0]])) begin
				res[0] = make_out(CHAR_PCT, 1'b0, ERR_NONE);
				res[1] = make_out(nib_char(b[7:4]), 1'b0, ERR_NONE);
				res[2] = make_out(nib_char(b[3:0]), 1'b0, ERR_NONE);
				n = 3;
			end else begin
				res[0] = make_out(b, 1'b0, ERR_NONE);
				n = 1;
			end
		end else if (err_m == ERR_NONE) begin
			if (phase_m == PH_IDLE) begin
				if (b == CHAR_PCT) begin
					phase_m = PH_HIGH;
				end else begin
					res[0] = make_out(b, 1'b0, ERR_NONE);
					n = 1;
				end
			end else begin
				v = char_nib(b);
				if (v[4]) begin
					err_m   = ERR_HEX;
					phase_m = PH_IDLE;
				end else if (phase_m == PH_HIGH) begin
					hi_nib_m = v[3:0];
					phase_m  = PH_LOW;
				end else begin
					res[0] = make_out({hi_nib_m, v[3:0]}, 1'b0, ERR_NONE);
					n = 1;
					phase_m  = PH_IDLE;
					hi_nib_m = 4'd0;
				end
			end
		end
		if (n > 0)
			res[n-1].last_in_run = 1'b1;
		for (int k = 0; k < n; k++)
			codec_out_q.push_back(res[k]);
	endfunction

	// Source driver: hold a stalled transfer, otherwise offer the next byte
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			src_item  <= '0;
		end else begin
			if (src_valid && !src_stall) begin
				percent_step(src_item);
				src_taken++;
			end
			if (!src_valid || !src_stall) begin
				if (src_feed_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					src_valid <= 1'b1;
					src_item  <= src_feed_q.pop_front();
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// Sink stall: random idling, or a long hold-off when one is requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_stall   <= 1'b0;
			hold_left   <= 0;
			hold_served <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			dst_stall <= 1'b1;
		end else if (hold_served < hold_req_n) begin
			hold_served <= hold_served + 1;
			hold_left   <= HOLD_CYCLES;
			dst_stall   <= 1'b1;
		end else begin
			dst_stall <= ($urandom_range(99) < dst_idle_pct);
		end
	end

	// Monitor: compare each output transfer with the oldest model result
	always @(posedge clk) begin
		if (arst_n && dst_valid && !dst_stall) begin
			results_seen++;
			if (codec_out_q.size() == 0) begin
				bad_count++;
				if (bad_count <= REPORT_LIMIT)
					$display("%0t: unexpected transfer: byte %02h st %0d code %0d last %0d",
						$realtime, dst_item.out_byte, dst_item.is_status,
						dst_item.error_code, dst_item.last_in_run);
			end else begin
				oldest_out = codec_out_q.pop_front();
				if (dst_item.out_byte !== oldest_out.out_byte ||
						dst_item.is_status !== oldest_out.is_status ||
						dst_item.error_code !== oldest_out.error_code ||
						dst_item.last_in_run !== oldest_out.last_in_run) begin
					bad_count++;
					if (bad_count <= REPORT_LIMIT)
						$display("%0t: want %02h/%0d/%0d/%0d got %02h/%0d/%0d/%0d",
							$realtime, oldest_out.out_byte, oldest_out.is_status,
							oldest_out.error_code, oldest_out.last_in_run,
							dst_item.out_byte, dst_item.is_status,
							dst_item.error_code, dst_item.last_in_run);
				end
			end
			if (dst_item.is_status) begin
				case (dst_item.error_code)
					ERR_NONE: status_ok++;
					ERR_HEX:  status_hex++;
					default:  status_cut++;
				endcase
			end
		end
	end

	// Watchdog: end the run when no transfer happens for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic feed_byte(input logic [7:0] c);
		in_item_t it;
		it.in_byte    = c;
		it.end_marker = 1'b0;
		src_feed_q.push_back(it);
	endtask

	task automatic feed_end(input logic [7:0] c);
		in_item_t it;
		it.in_byte    = c;
		it.end_marker = 1'b1;
		src_feed_q.push_back(it);
	endtask

	function automatic logic [7:0] rand_hex_char();
		logic [3:0] nib;
		nib = 4'($urandom_range(15));
		if (nib < 4'd10)
			return CH_ZERO + {4'd0, nib};
		if ($urandom_range(1))
			return CH_LOWER + {4'd0, nib} - 8'd10;
		return CH_UPPER + {4'd0, nib} - 8'd10;
	endfunction

	function automatic logic [7:0] rand_non_hex();
		logic [7:0] c;
		logic [4:0] v;
		do begin
			c = 8'($urandom_range(255));
			v = char_nib(c);
		end while (!v[4]);
		return c;
	endfunction

	// Plain string for encode mode: raw bytes and printable text
	task automatic feed_encode_string(inout int cnt);
		int len;
		len = $urandom_range(10);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(1))
				feed_byte(8'($urandom_range(255)));
			else
				feed_byte(8'($urandom_range(126, 32)));
		end
		feed_end(8'($urandom_range(255)));
		cnt += len + 1;
	endtask

	// Escaped string for decode mode: mostly well formed, some broken
	task automatic feed_decode_string(inout int cnt);
		int         toks;
		int         kind;
		logic [7:0] c;
		toks = $urandom_range(8);
		for (int k = 0; k < toks; k++) begin
			kind = $urandom_range(99);
			if (kind < 50) begin
				feed_byte(CHAR_PCT);
				feed_byte(rand_hex_char());
				feed_byte(rand_hex_char());
				cnt += 3;
			end else if (kind < 85) begin
				do
					c = 8'($urandom_range(255));
				while (c == CHAR_PCT);
				feed_byte(c);
				cnt += 1;
			end else if (kind < 92) begin
				feed_byte(CHAR_PCT);
				feed_byte(rand_non_hex());
				cnt += 2;
			end else begin
				feed_byte(CHAR_PCT);
				feed_byte(rand_hex_char());
				feed_byte(rand_non_hex());
				cnt += 3;
			end
		end
		// Cut some strings short inside an escape
		kind = $urandom_range(99);
		if (kind < 8) begin
			feed_byte(CHAR_PCT);
			cnt += 1;
		end else if (kind < 15) begin
			feed_byte(CHAR_PCT);
			feed_byte(rand_hex_char());
			cnt += 2;
		end
		feed_end(8'($urandom_range(255)));
		cnt += 1;
	endtask

	// Write one register while the codec is idle
	task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MODE:     mode_m = val[0];
			CFG_ESC_LOW:  esc_low_m = val;
			CFG_ESC_HIGH: esc_high_m = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Hold off new stimulus until every outstanding result has come out
	task automatic wait_drain();
		do
			@(negedge clk);
		while (src_feed_q.size() != 0 || src_valid || codec_out_q.size() != 0);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	initial begin
		int          cnt;
		int          sel;
		logic [63:0] low_v;
		logic [63:0] high_v;

		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_MODE;
		cfg_data     = '0;
		mode_m       = MODE_ENCODE;
		esc_low_m    = ESC_LOW_RST;
		esc_high_m   = ESC_HIGH_RST;
		phase_m      = PH_IDLE;
		hi_nib_m     = 4'd0;
		err_m        = ERR_NONE;
		src_idle_pct = 28;
		dst_idle_pct = 61;
		hold_req_n   = 0;
		idle_cycles  = 0;
		src_taken    = 0;
		results_seen = 0;
		bad_count    = 0;
		status_ok    = 0;
		status_hex   = 0;
		status_cut   = 0;
		phases_run   = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Encode with reset bitmaps: zero byte, space, letter, top bytes, percent
		feed_byte(8'h00);
		feed_byte(8'h20);
		feed_byte(8'h41);
		feed_byte(8'hFF);
		feed_byte(8'h80);
		feed_byte(8'h7F);
		feed_byte(CHAR_PCT);
		feed_end(8'h00);
		wait_drain();

		// Decode: both digit cases, pass-through, bad digit, escapes cut by end
		cfg_write(CFG_MODE, 64'(MODE_DECODE));
		feed_byte(CHAR_PCT);
		feed_byte(8'h34);
		feed_byte(8'h31);
		feed_byte(CHAR_PCT);
		feed_byte(8'h61);
		feed_byte(8'h46);
		feed_byte(8'h78);
		feed_end(8'h00);
		feed_byte(CHAR_PCT);
		feed_byte(8'h47);
		feed_byte(8'h7A);
		feed_end(8'hFF);
		feed_byte(CHAR_PCT);
		feed_byte(8'h33);
		feed_end(8'h00);
		feed_end(8'h00);
		feed_byte(CHAR_PCT);
		feed_end(8'h00);
		wait_drain();

		// Mode change in the middle of a pending escape
		feed_byte(CHAR_PCT);
		feed_byte(8'h34);
		wait_drain();
		cfg_write(CFG_MODE, 64'(MODE_ENCODE));
		feed_byte(8'h42);
		wait_drain();
		cfg_write(CFG_MODE, 64'(MODE_DECODE));
		feed_byte(8'h31);
		feed_end(8'h00);
		wait_drain();

		// Random phases over modes, bitmap extremes and idle profiles
		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p == 4) begin
				src_idle_pct = 61;
				dst_idle_pct = 28;
			end else if (p == 8) begin
				src_idle_pct = 0;
				dst_idle_pct = 0;
			end
			sel = (p / 2) % 4;
			case (sel)
				0: begin
					low_v  = '0;
					high_v = '0;
				end
				1: begin
					low_v  = '1;
					high_v = '1;
				end
				2: begin
					low_v  = ESC_LOW_RST;
					high_v = ESC_HIGH_RST;
				end
				default: begin
					low_v  = {32'($urandom), 32'($urandom)};
					high_v = {32'($urandom), 32'($urandom)};
				end
			endcase
			cfg_write(CFG_ESC_LOW, low_v);
			cfg_write(CFG_ESC_HIGH, high_v);
			cfg_write(CFG_MODE, (p % 2) ? 64'(MODE_DECODE) : 64'(MODE_ENCODE));
			// Long sink hold-off while the source keeps offering
			if (p == 1 || p == 6 || p == 10)
				hold_req_n++;
			cnt = 0;
			while (cnt < PHASE_ITEMS) begin
				if (mode_m == MODE_DECODE)
					feed_decode_string(cnt);
				else
					feed_encode_string(cnt);
			end
			wait_drain();
			phases_run++;
		end

		$display("Covered %0d input transfers and %0d output transfers over %0d random phases.",
			src_taken, results_seen, phases_run);
		$display("Status results: %0d ok, %0d bad hex digit, %0d escape cut short.",
			status_ok, status_hex, status_cut);
		if (bad_count == 0 && codec_out_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d failures, %0d results never seen", bad_count, codec_out_q.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
